@@ hw/rtl/dbtl_pkg.sv @@
// Package for the dual-bank tile layer unit: operation codes, memory sizing
// and the fixed scroll base table. No dependencies.
`default_nettype none

package dbtl_pkg;

    localparam int LAYER_WORDS = 4096;
    localparam int LW_BITS     = $clog2(LAYER_WORDS);
    localparam int SLOT_BITS   = 3;
    localparam int MEM_AW      = SLOT_BITS + LW_BITS;
    localparam int MEM_DEPTH   = 8 * LAYER_WORDS;

    localparam logic [2:0] OP_VRAM_WR   = 3'd0;
    localparam logic [2:0] OP_SCROLL_WR = 3'd1;
    localparam logic [2:0] OP_BANK_WR   = 3'd2;
    localparam logic [2:0] OP_DISP_SEL  = 3'd3;
    localparam logic [2:0] OP_FETCH     = 3'd4;

    // Base subtracted from a scroll register write, by window and register.
    function automatic logic [15:0] scroll_base(input logic [1:0] win,
                                                input logic [1:0] regno);
        logic [15:0] b;
        case ({win, regno})
            4'b0000: b = 16'h0000;
            4'b0001: b = 16'h0000;
            4'b0010: b = 16'h0004;
            4'b0011: b = 16'h0000;
            4'b0100: b = 16'h01be;
            4'b0101: b = 16'h01ef;
            4'b0110: b = 16'h01c2;
            4'b0111: b = 16'h01ef;
            4'b1000: b = 16'h01c0;
            4'b1001: b = 16'h01ef;
            4'b1010: b = 16'h01c3;
            4'b1011: b = 16'h01ef;
            4'b1100: b = 16'h01bf;
            4'b1101: b = 16'h01ef;
            4'b1110: b = 16'h01c3;
            4'b1111: b = 16'h01ef;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dbtl_if.sv @@
// Item channels of the dual-bank tile layer unit: the request channel and
// the result channel. Each carries valid, ready and the payload fields.
`default_nettype none

interface dbtl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [1:0]  target;
    logic [12:0] offset;
    logic [15:0] data;
    logic [1:0]  byte_enable;

    modport source (output valid, output op, output target, output offset,
                    output data, output byte_enable, input ready);
    modport sink   (input valid, input op, input target, input offset,
                    input data, input byte_enable, output ready);
endinterface

interface dbtl_rsp_if;
    logic        valid;
    logic        ready;
    logic        fetch_valid;
    logic [17:0] tile_code;
    logic [4:0]  tile_color;
    logic [15:0] scroll_x;
    logic [15:0] scroll_y;

    modport source (output valid, output fetch_valid, output tile_code,
                    output tile_color, output scroll_x, output scroll_y,
                    input ready);
    modport sink   (input valid, input fetch_valid, input tile_code,
                    input tile_color, input scroll_x, input scroll_y,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dual_bank_tile_layer_unit.sv @@
// Dual-bank tile layer unit: layer RAM with byte-enable writes, scroll and
// tile bank registers. Depends on dbtl_pkg and the channels in dbtl_if.
// An accepted item passes through the read stage registers and then the output registers before its result is shown.
// Throughput: one item per cycle; a stalled result blocks input once both stages hold items.
// Reset: scroll values, tile banks, display bank and pipeline valids clear at once;
// the layer RAM is not cleared and holds nothing defined until written.
`default_nettype none

module dual_bank_tile_layer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dbtl_req_if.sink    req,
    dbtl_rsp_if.source  rsp
);
    import dbtl_pkg::*;

    logic [15:0] mem [MEM_DEPTH];
    logic [15:0] rd_data_reg;

    logic [15:0] hscroll_reg [8];
    logic [15:0] vscroll_reg [8];
    logic [3:0]  tbank_reg [8];
    logic        disp_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_fetch_reg;
    logic [3:0]  s1_tbank_reg;
    logic [15:0] s1_sx_reg;
    logic [15:0] s1_sy_reg;
    logic        s1_disp_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_fetch_reg;
    logic [17:0] out_code_reg;
    logic [4:0]  out_color_reg;
    logic [15:0] out_sx_reg;
    logic [15:0] out_sy_reg;

    logic        accept;
    logic        s1_adv;
    logic        mem_wr;
    logic        mem_rd;
    logic [2:0]  wr_slot;
    logic [2:0]  rd_slot;
    logic [2:0]  scr_slot;
    logic [31:0] wr_word32;
    logic [31:0] rd_word32;
    logic [MEM_AW-1:0] wr_addr;
    logic [MEM_AW-1:0] rd_addr;
    logic [15:0] scr_value;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    // Window n writes bank n[1], layer pair n[0]; offset bit 12 picks the layer.
    assign wr_slot   = {req.target[1], req.target[0], req.offset[12]};
    assign wr_word32 = 32'(req.offset[11:0]);
    assign wr_addr   = {wr_slot, wr_word32[LW_BITS-1:0]};
    assign rd_slot   = {disp_reg, req.target};
    assign rd_word32 = 32'(req.offset);
    assign rd_addr   = {rd_slot, rd_word32[LW_BITS-1:0]};

    // Scroll windows swap the roles of the two target bits.
    assign scr_slot  = {req.target[0], req.target[1], req.offset[1]};
    assign scr_value = req.data - scroll_base(req.target, req.offset[1:0]);

    assign mem_wr = accept && (req.op == OP_VRAM_WR);
    assign mem_rd = accept && (req.op == OP_FETCH);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            if (req.byte_enable[0])
            begin
                mem[wr_addr][7:0] <= req.data[7:0];
            end
            if (req.byte_enable[1])
            begin
                mem[wr_addr][15:8] <= req.data[15:8];
            end
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hscroll_reg[i] <= '0;
                vscroll_reg[i] <= '0;
                tbank_reg[i]   <= '0;
            end
            disp_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (req.op)
                OP_SCROLL_WR:
                begin
                    if (req.offset[12:2] == '0)
                    begin
                        if (req.offset[0])
                        begin
                            vscroll_reg[scr_slot] <= scr_value;
                        end
                        else
                        begin
                            hscroll_reg[scr_slot] <= scr_value;
                        end
                    end
                end
                OP_BANK_WR:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        tbank_reg[{req.target[0], 2'(i)}] <= req.data[4*i +: 4];
                    end
                end
                OP_DISP_SEL:
                begin
                    disp_reg <= (req.data != '0);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_fetch_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_fetch_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_fetch_reg <= (req.op == OP_FETCH);
            end
            if (s1_adv)
            begin
                out_fetch_reg <= s1_fetch_reg;
            end
        end
    end

    // The fetched slot's side registers travel with the RAM read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tbank_reg <= tbank_reg[rd_slot];
            s1_sx_reg    <= hscroll_reg[rd_slot];
            s1_sy_reg    <= vscroll_reg[rd_slot];
            s1_disp_reg  <= disp_reg;
        end
        if (s1_adv)
        begin
            if (s1_fetch_reg)
            begin
                out_code_reg  <= {s1_tbank_reg, rd_data_reg[13:0]};
                out_color_reg <= {s1_disp_reg, 2'b00, rd_data_reg[15:14]};
                out_sx_reg    <= s1_sx_reg;
                out_sy_reg    <= s1_sy_reg;
            end
            else
            begin
                out_code_reg  <= '0;
                out_color_reg <= '0;
                out_sx_reg    <= '0;
                out_sy_reg    <= '0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.fetch_valid = out_fetch_reg;
    assign rsp.tile_code   = out_code_reg;
    assign rsp.tile_color  = out_color_reg;
    assign rsp.scroll_x    = out_sx_reg;
    assign rsp.scroll_y    = out_sy_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the read stage");

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_fetch_reg && !s1_adv |=> s1_valid_reg && $stable(rd_data_reg))
        else $error("read data changed while the read stage was stalled");

    a_nonfetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.fetch_valid |->
            rsp.tile_code == '0 && rsp.tile_color == '0 &&
            rsp.scroll_x == '0 && rsp.scroll_y == '0)
        else $error("non-fetch result carries nonzero fields");

    a_color_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.fetch_valid |-> rsp.tile_color[3:2] == 2'b00)
        else $error("tile color has bits outside the colour and bank fields");

endmodule

`default_nettype wire

@@ tb/dual_bank_tile_layer_unit_tb.sv @@
// Self-checking testbench for dual_bank_tile_layer_unit: a directed opening and then random
// bus writes and tile fetches, with results checked against an in-bench model of the layers.
// Depends on dbtl_pkg, dbtl_req_if/dbtl_rsp_if and the unit itself.
`default_nettype none

module dual_bank_tile_layer_unit_tb;

    import dbtl_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int         PHASE_ITEMS    = 415;
    localparam int         RAM_WORDS      = 8 * LAYER_WORDS;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  target;
        logic [12:0] offset;
        logic [15:0] data;
        logic [1:0]  byte_enable;
    } tile_req_t;

    typedef struct packed {
        logic        fetch_valid;
        logic [17:0] tile_code;
        logic [4:0]  tile_color;
        logic [15:0] scroll_x;
        logic [15:0] scroll_y;
    } tile_result_t;

    logic clk;
    logic rst_n;

    dbtl_req_if req_ch ();
    dbtl_rsp_if rsp_ch ();

    dual_bank_tile_layer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Layer state as the unit should hold it, updated on each accepted item.
    logic [15:0] tile_ram [RAM_WORDS];
    logic [15:0] scroll_h [8];
    logic [15:0] scroll_v [8];
    logic [3:0]  bank_nibble [8];
    logic        shown_bank;

    // Stimulus-side view: which bytes have been written and which bank is shown.
    bit [1:0]    bytes_written [RAM_WORDS];
    bit          gen_shown_bank;
    int unsigned full_words_bank0 [$];
    int unsigned full_words_bank1 [$];

    tile_req_t    pending_reqs [$];
    tile_result_t expected_results [$];
    tile_req_t    next_req;
    int           queued_count;
    int           accepted_count;
    int           fail_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    logic         req_fired;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [15:0] scroll_base_of(logic [1:0] win, logic [1:0] regno);
        if (regno[0])
            return (win == 2'd0) ? 16'h0000 : 16'h01ef;
        case ({win, regno[1]})
            3'b000:  return 16'h0000;
            3'b001:  return 16'h0004;
            3'b010:  return 16'h01be;
            3'b011:  return 16'h01c2;
            3'b100:  return 16'h01c0;
            3'b101:  return 16'h01c3;
            3'b110:  return 16'h01bf;
            default: return 16'h01c3;
        endcase
    endfunction

    function automatic void reset_layer_state();
        for (int i = 0; i < 8; i++)
        begin
            scroll_h[i]    = '0;
            scroll_v[i]    = '0;
            bank_nibble[i] = '0;
        end
        shown_bank = 1'b0;
    endfunction

    function automatic tile_result_t apply_layer_op(tile_req_t r);
        tile_result_t res;
        logic [2:0]   slot;
        int unsigned  addr;
        logic [15:0]  word;
        res = '0;
        case (r.op)
            OP_VRAM_WR:
            begin
                slot = {r.target, r.offset[12]};
                addr = 32'({slot, r.offset[11:0]});
                if (r.byte_enable[0])
                    tile_ram[addr][7:0] = r.data[7:0];
                if (r.byte_enable[1])
                    tile_ram[addr][15:8] = r.data[15:8];
            end
            OP_SCROLL_WR:
            begin
                if (r.offset < 13'd4)
                begin
                    // Scroll windows interleave banks: 0 and 2 are bank 0, 1 and 3 bank 1.
                    slot = {r.target[0], r.target[1], r.offset[1]};
                    if (r.offset[0])
                        scroll_v[slot] = r.data - scroll_base_of(r.target, r.offset[1:0]);
                    else
                        scroll_h[slot] = r.data - scroll_base_of(r.target, r.offset[1:0]);
                end
            end
            OP_BANK_WR:
            begin
                for (int i = 0; i < 4; i++)
                    bank_nibble[{r.target[0], 2'(i)}] = r.data[4 * i +: 4];
            end
            OP_DISP_SEL:
                shown_bank = (r.data != 16'h0);
            OP_FETCH:
            begin
                slot = {shown_bank, r.target};
                addr = 32'({slot, r.offset[11:0]});
                word = tile_ram[addr];
                res.fetch_valid = 1'b1;
                res.tile_code   = {bank_nibble[slot], word[13:0]};
                res.tile_color  = {shown_bank, 2'b00, word[15:14]};
                res.scroll_x    = scroll_h[slot];
                res.scroll_y    = scroll_v[slot];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_item(logic [2:0] op, logic [1:0] target, logic [12:0] offset,
                                       logic [15:0] data, logic [1:0] byte_enable);
        tile_req_t   r;
        int unsigned addr;
        r = '{op, target, offset, data, byte_enable};
        if (op == OP_VRAM_WR)
        begin
            addr = 32'({target, offset[12], offset[11:0]});
            if (bytes_written[addr] != 2'b11 && (bytes_written[addr] | byte_enable) == 2'b11)
            begin
                if (addr[14])
                    full_words_bank1.push_back(addr);
                else
                    full_words_bank0.push_back(addr);
            end
            bytes_written[addr] |= byte_enable;
        end
        else if (op == OP_DISP_SEL)
            gen_shown_bank = (data != 16'h0);
        pending_reqs.push_back(r);
        queued_count++;
    endfunction

    // A fetch only ever reads a word whose both bytes were written earlier.
    function automatic void queue_fetch();
        int unsigned addr;
        int          n;
        n = gen_shown_bank ? full_words_bank1.size() : full_words_bank0.size();
        if (n == 0)
        begin
            queue_item(OP_VRAM_WR, {gen_shown_bank, 1'($urandom)}, 13'($urandom),
                       16'($urandom), 2'b11);
            n = 1;
        end
        if (gen_shown_bank)
            addr = full_words_bank1[$urandom_range(0, full_words_bank1.size() - 1)];
        else
            addr = full_words_bank0[$urandom_range(0, full_words_bank0.size() - 1)];
        queue_item(OP_FETCH, addr[13:12], {1'($urandom), addr[11:0]}, 16'($urandom),
                   2'($urandom));
    endfunction

    // Returns 0 for a spare op code or a scroll write outside the four registers, else 1.
    function automatic bit queue_random_item();
        int          pick;
        logic [12:0] regno;
        logic [15:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            queue_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 2'($urandom),
                       13'($urandom), 16'($urandom), 2'($urandom));
            return 1'b0;
        end
        else if (pick < 36)
            queue_item(OP_VRAM_WR, 2'($urandom), 13'($urandom), 16'($urandom),
                       ($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom));
        else if (pick < 46)
        begin
            regno = ($urandom_range(0, 9) < 8) ? 13'($urandom_range(0, 3)) : 13'($urandom);
            queue_item(OP_SCROLL_WR, 2'($urandom), regno, 16'($urandom), 2'($urandom));
            return regno < 13'd4;
        end
        else if (pick < 52)
            queue_item(OP_BANK_WR, 2'($urandom), 13'($urandom), 16'($urandom), 2'($urandom));
        else if (pick < 56)
        begin
            value = $urandom_range(0, 1) ? 16'h0 : 16'($urandom);
            queue_item(OP_DISP_SEL, 2'($urandom), 13'($urandom), value, 2'($urandom));
        end
        else
            queue_fetch();
        return 1'b1;
    endfunction

    function automatic void queue_directed_items();
        queue_item(OP_VRAM_WR, 2'd0, 13'h0000, 16'hffff, 2'b11);
        queue_item(OP_VRAM_WR, 2'd0, 13'h1fff, 16'h0000, 2'b11);
        queue_item(OP_VRAM_WR, 2'd3, 13'h1000, 16'hc001, 2'b11);
        queue_item(OP_VRAM_WR, 2'd1, 13'h0fff, 16'h8000, 2'b11);
        queue_item(OP_VRAM_WR, 2'd0, 13'h0000, 16'h1234, 2'b01);
        queue_item(OP_VRAM_WR, 2'd0, 13'h0000, 16'hab00, 2'b10);
        // Without byte enables the word must stay as it is.
        queue_item(OP_VRAM_WR, 2'd0, 13'h0000, 16'h5555, 2'b00);
        // Scroll bases are subtracted modulo 65536, so small data wraps around.
        queue_item(OP_SCROLL_WR, 2'd1, 13'd0, 16'h0000, 2'b00);
        queue_item(OP_SCROLL_WR, 2'd3, 13'd3, 16'hffff, 2'b11);
        queue_item(OP_SCROLL_WR, 2'd2, 13'd2, 16'h01c3, 2'b00);
        queue_item(OP_SCROLL_WR, 2'd0, 13'd1, 16'h8000, 2'b00);
        queue_item(OP_SCROLL_WR, 2'd0, 13'd4, 16'h7777, 2'b00);
        queue_item(OP_SCROLL_WR, 2'd2, 13'h1fff, 16'h7777, 2'b00);
        queue_item(OP_BANK_WR, 2'd0, 13'd0, 16'hfedc, 2'b00);
        queue_item(OP_BANK_WR, 2'd3, 13'h1fff, 16'h1234, 2'b00);
        queue_item(OP_FETCH, 2'd0, 13'h0000, 16'h0000, 2'b00);
        queue_item(OP_FETCH, 2'd1, 13'h1fff, 16'hffff, 2'b11);
        queue_item(OP_FETCH, 2'd2, 13'h0fff, 16'h0000, 2'b00);
        queue_item(OP_SPARE_FIRST, 2'd0, 13'h0000, 16'hffff, 2'b11);
        queue_item(OP_SPARE_LAST, 2'd3, 13'h1fff, 16'hffff, 2'b11);
        queue_item(OP_DISP_SEL, 2'd0, 13'd0, 16'h0100, 2'b00);
        queue_item(OP_FETCH, 2'd3, 13'h1000, 16'h0000, 2'b00);
        queue_item(OP_DISP_SEL, 2'd0, 13'd0, 16'h0000, 2'b00);
    endfunction

    function automatic void compare_result(tile_result_t got, tile_result_t want);
        if (got.fetch_valid !== want.fetch_valid)
        begin
            $error("fetch_valid: expected %0d, got %0d", want.fetch_valid, got.fetch_valid);
            fail_count++;
        end
        if (got.tile_code !== want.tile_code)
        begin
            $error("tile_code: expected %h, got %h", want.tile_code, got.tile_code);
            fail_count++;
        end
        if (got.tile_color !== want.tile_color)
        begin
            $error("tile_color: expected %h, got %h", want.tile_color, got.tile_color);
            fail_count++;
        end
        if (got.scroll_x !== want.scroll_x)
        begin
            $error("scroll_x: expected %h, got %h", want.scroll_x, got.scroll_x);
            fail_count++;
        end
        if (got.scroll_y !== want.scroll_y)
        begin
            $error("scroll_y: expected %h, got %h", want.scroll_y, got.scroll_y);
            fail_count++;
        end
    endfunction

    // Request driver: a held item stays on the bus until the edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_fired)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.op          <= next_req.op;
                    req_ch.target      <= next_req.target;
                    req_ch.offset      <= next_req.offset;
                    req_ch.data        <= next_req.data;
                    req_ch.byte_enable <= next_req.byte_enable;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_fired <= 1'b0;
        else
        begin
            req_fired <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_layer_op('{req_ch.op, req_ch.target,
                    req_ch.offset, req_ch.data, req_ch.byte_enable}));
                accepted_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding: tile_code %h", rsp_ch.tile_code);
                    fail_count++;
                end
                else
                    compare_result('{rsp_ch.fetch_valid, rsp_ch.tile_code, rsp_ch.tile_color,
                                     rsp_ch.scroll_x, rsp_ch.scroll_y},
                                   expected_results.pop_front());
            end
        end
    end

    initial
    begin
        int counted;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_VRAM_WR;
        req_ch.target      = '0;
        req_ch.offset      = '0;
        req_ch.data        = '0;
        req_ch.byte_enable = '0;
        rsp_ch.ready       = 1'b0;
        queued_count       = 0;
        accepted_count     = 0;
        fail_count         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        gen_shown_bank     = 1'b0;
        reset_layer_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
                default: begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
            endcase
            if (phase == 0)
                queue_directed_items();
            counted = 0;
            while (counted < PHASE_ITEMS)
                if (queue_random_item())
                    counted++;
            while (accepted_count != queued_count || expected_results.size() != 0)
                @(posedge clk);
        end

        // Let any stray result show up before the verdict.
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
